// ===== hw/rtl/hps_pkg.sv =====
package hps_pkg;

  localparam int unsigned WaitWidth  = 16;
  localparam int unsigned PressWidth = 7;
  localparam int unsigned CountWidth = 8;
  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [WaitWidth-1:0]  BootWaitReset     = 16'd600;
  localparam logic [WaitWidth-1:0]  ShutdownWaitReset = 16'd600;
  localparam logic [PressWidth-1:0] LongPressReset    = 7'd80;
  localparam logic [PressWidth-1:0] ShortPressReset   = 7'd3;

  localparam logic signed [CountWidth-1:0] PressMax = 8'sd127;

  localparam logic [CfgIdxWidth-1:0] CfgBootWait     = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgShutdownWait = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgLongPress    = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CfgShortPress   = 2'd3;

  typedef enum logic [2:0] {
    MODE_HALTED   = 3'd0,
    MODE_BOOTING  = 3'd1,
    MODE_RUNNING  = 3'd2,
    MODE_SHUTDOWN = 3'd3,
    MODE_RESET    = 3'd4
  } mode_t;

  typedef struct packed {
    logic [WaitWidth-1:0]  boot_wait_ticks;
    logic [WaitWidth-1:0]  shutdown_wait_ticks;
    logic [PressWidth-1:0] long_press_ticks;
    logic [PressWidth-1:0] short_press_ticks;
  } cfg_t;

  typedef struct packed {
    logic switch_down;
    logic switch_event;
    logic host_ready;
    logic ready_recheck;
    logic ready_event;
  } tick_t;

  typedef struct packed {
    mode_t                         mode;
    logic signed [CountWidth-1:0]  press_count;
    logic [WaitWidth-1:0]          wait_count;
    logic                          relay;
    logic                          led_green;
    logic                          led_red;
    logic                          drv_shutdown;
    logic                          drv_reset;
  } seq_state_t;

endpackage

// ===== hw/rtl/hps_if.sv =====
interface hps_tick_if;
  logic valid;
  logic ready;
  logic switch_down;
  logic switch_event;
  logic host_ready;
  logic ready_recheck;
  logic ready_event;

  modport source (output valid, switch_down, switch_event, host_ready, ready_recheck,
                  ready_event, input ready);
  modport sink (input valid, switch_down, switch_event, host_ready, ready_recheck,
                ready_event, output ready);
endinterface

interface hps_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic       power_on;
  logic       led_green;
  logic       led_red;
  logic       shutdown_drive;
  logic       reset_drive;

  modport source (output valid, mode, power_on, led_green, led_red, shutdown_drive,
                  reset_drive, input ready);
  modport sink (input valid, mode, power_on, led_green, led_red, shutdown_drive,
                reset_drive, output ready);
endinterface

// ===== hw/rtl/hps_cfg.sv =====
module hps_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [hps_pkg::CfgIdxWidth-1:0]      cfg_index,
  input  logic [hps_pkg::CfgWidth-1:0]         cfg_data,
  output hps_pkg::cfg_t                        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.boot_wait_ticks     <= hps_pkg::BootWaitReset;
      cfg.shutdown_wait_ticks <= hps_pkg::ShutdownWaitReset;
      cfg.long_press_ticks    <= hps_pkg::LongPressReset;
      cfg.short_press_ticks   <= hps_pkg::ShortPressReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hps_pkg::CfgBootWait:     cfg.boot_wait_ticks     <= cfg_data;
        hps_pkg::CfgShutdownWait: cfg.shutdown_wait_ticks <= cfg_data;
        hps_pkg::CfgLongPress:    cfg.long_press_ticks    <= cfg_data[hps_pkg::PressWidth-1:0];
        hps_pkg::CfgShortPress:   cfg.short_press_ticks   <= cfg_data[hps_pkg::PressWidth-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/hps_core.sv =====
module hps_core (
  input  hps_pkg::cfg_t       cfg,
  input  hps_pkg::tick_t      tick,
  input  hps_pkg::seq_state_t st,
  output hps_pkg::seq_state_t st_next
);

  function automatic hps_pkg::seq_state_t enter_mode(hps_pkg::seq_state_t s,
                                                     hps_pkg::mode_t m,
                                                     hps_pkg::cfg_t c);
    hps_pkg::seq_state_t r;
    r = s;
    r.mode = m;
    unique case (m)
      hps_pkg::MODE_BOOTING: begin
        r.relay      = 1'b1;
        r.wait_count = c.boot_wait_ticks;
        r.led_green  = 1'b1;
        r.led_red    = 1'b0;
      end
      hps_pkg::MODE_RUNNING: begin
        r.led_green = 1'b1;
        r.led_red   = 1'b0;
      end
      hps_pkg::MODE_SHUTDOWN: begin
        r.wait_count   = c.shutdown_wait_ticks;
        r.led_green    = 1'b0;
        r.led_red      = 1'b1;
        r.drv_shutdown = 1'b1;
      end
      hps_pkg::MODE_RESET: begin
        r.led_green = 1'b0;
        r.led_red   = 1'b1;
        r.drv_reset = 1'b1;
      end
      default: begin
        r.mode      = hps_pkg::MODE_HALTED;
        r.led_green = 1'b0;
        r.led_red   = 1'b1;
      end
    endcase
    return r;
  endfunction

  always_comb begin
    hps_pkg::seq_state_t s;
    logic signed [hps_pkg::CountWidth:0] short_neg;
    s = st;
    short_neg = -$signed({2'b00, cfg.short_press_ticks});

    // ready event outside halted mode wins over a new press in the same tick
    if (tick.ready_event && s.mode != hps_pkg::MODE_HALTED) begin
      s = enter_mode(s, hps_pkg::MODE_SHUTDOWN, cfg);
    end else if (tick.switch_event && s.press_count == '0) begin
      s.press_count = 8'sd1;
    end

    if (s.press_count > 0) begin
      if (tick.switch_down) begin
        if (s.press_count < hps_pkg::PressMax) begin
          s.press_count = s.press_count + 8'sd1;
          if (s.press_count == $signed({1'b0, cfg.long_press_ticks})) begin
            s = enter_mode(s, hps_pkg::MODE_RESET, cfg);
          end
        end
      end else begin
        // release: hold the held length as a negative count
        s.press_count = -s.press_count;
      end
    end else begin
      if (s.mode != hps_pkg::MODE_RESET &&
          $signed({s.press_count[hps_pkg::CountWidth-1], s.press_count}) < short_neg) begin
        s = enter_mode(s, (s.mode == hps_pkg::MODE_HALTED) ? hps_pkg::MODE_BOOTING
                                                           : hps_pkg::MODE_SHUTDOWN, cfg);
      end
      s.press_count = '0;

      unique case (s.mode)
        hps_pkg::MODE_BOOTING: begin
          s.led_green = ~s.led_green;
          if (tick.host_ready) begin
            if (tick.ready_recheck) begin
              s = enter_mode(s, hps_pkg::MODE_RUNNING, cfg);
            end
          end else begin
            s.wait_count = s.wait_count - 16'd1;
            if (s.wait_count == '0) begin
              s = enter_mode(s, hps_pkg::MODE_HALTED, cfg);
            end
          end
        end
        hps_pkg::MODE_SHUTDOWN: begin
          s.led_red = ~s.led_red;
          if (!tick.host_ready) begin
            s.drv_shutdown = 1'b0;
            s = enter_mode(s, hps_pkg::MODE_HALTED, cfg);
          end else begin
            s.wait_count = s.wait_count - 16'd1;
            if (s.wait_count == '0) begin
              s = enter_mode(s, hps_pkg::MODE_RUNNING, cfg);
            end
          end
        end
        hps_pkg::MODE_HALTED: begin
          s.relay = 1'b0;
        end
        hps_pkg::MODE_RESET: begin
          s.drv_reset = 1'b0;
          s = enter_mode(s, hps_pkg::MODE_BOOTING, cfg);
        end
        default: ;
      endcase
    end

    st_next = s;
  end

endmodule

// ===== hw/rtl/host_power_sequencer.sv =====
// Host power sequencer: one tick beat in, one result beat out.
// The result of a tick is valid in the cycle after the tick is accepted.
// Throughput: one tick per cycle while result.ready holds; sequencer state updates in
// the accept cycle and the result sits in an output register while the next tick is taken.
// Reset (rst, synchronous): halted, red LED on, drives released, registers at defaults.
module host_power_sequencer (
  input  logic                            clk,
  input  logic                            rst,
  hps_tick_if.sink                        tick,
  hps_result_if.source                    result,
  input  logic                            cfg_we,
  input  logic [hps_pkg::CfgIdxWidth-1:0] cfg_index,
  input  logic [hps_pkg::CfgWidth-1:0]    cfg_data
);

  hps_pkg::cfg_t       cfg;
  hps_pkg::tick_t      tick_in;
  hps_pkg::seq_state_t st;
  hps_pkg::seq_state_t st_next;
  logic                accept;

  hps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign tick_in.switch_down   = tick.switch_down;
  assign tick_in.switch_event  = tick.switch_event;
  assign tick_in.host_ready    = tick.host_ready;
  assign tick_in.ready_recheck = tick.ready_recheck;
  assign tick_in.ready_event   = tick.ready_event;

  hps_core u_core (
    .cfg     (cfg),
    .tick    (tick_in),
    .st      (st),
    .st_next (st_next)
  );

  assign tick.ready = !result.valid || result.ready;
  assign accept     = tick.valid && tick.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode         <= hps_pkg::MODE_HALTED;
      st.press_count  <= '0;
      st.wait_count   <= '0;
      st.relay        <= 1'b0;
      st.led_green    <= 1'b0;
      st.led_red      <= 1'b1;
      st.drv_shutdown <= 1'b0;
      st.drv_reset    <= 1'b0;
      result.valid    <= 1'b0;
    end else begin
      if (accept) begin
        st <= st_next;
      end
      // drop the beat once taken, load a new one on accept
      if (accept) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.mode           <= st_next.mode;
      result.power_on       <= st_next.relay;
      result.led_green      <= st_next.led_green;
      result.led_red        <= st_next.led_red;
      result.shutdown_drive <= st_next.drv_shutdown;
      result.reset_drive    <= st_next.drv_reset;
    end
  end

endmodule
